FILE: hw/rtl/jmta_pkg.sv
// ----------------------------------------------------------------------------
// Joint angle tracker package
// Shared types, fixed-point turn constants and the angle wrap function.
// ----------------------------------------------------------------------------
package jmta_pkg;

   localparam int SampleW = 20;
   localparam int ExtW    = 48;
   localparam int ThrW    = 19;

   typedef logic signed [SampleW-1:0] sample_type;
   typedef logic signed [ExtW-1:0]    ext_type;
   typedef logic [ThrW-1:0]           thr_type;

   typedef enum logic {
      OP_INIT   = 1'b0,
      OP_UPDATE = 1'b1
   } op_type;

   typedef struct packed {
      logic       initialized;
      sample_type previous;
      sample_type remainder;
      ext_type    extended;
   } joint_state_type;

   // One full turn and half a turn in Q.16 radians.
   localparam logic signed [SampleW:0] TwoPiS   = 21'sd411775;
   localparam logic signed [SampleW:0] PiS      = 21'sd205887;
   localparam logic signed [SampleW:0] NegBound = PiS - TwoPiS;

   localparam thr_type ThrReset = 19'd205887;

   localparam longint ExtMaxL  = 64'sd140737488355327;
   localparam longint ExtMinL  = -64'sd140737488355328;
   localparam longint TwoPiL   = 64'sd411775;
   localparam ext_type ExtMaxQ = ext_type'(ExtMaxL);
   localparam ext_type ExtMinQ = ext_type'(ExtMinL);

   // Truncated remainders of the clip limits by one turn.
   localparam sample_type RemMax = sample_type'(ExtMaxL % TwoPiL);
   localparam sample_type RemMin = sample_type'(ExtMinL % TwoPiL);

   function automatic sample_type norm_angle(sample_type x);
      logic signed [SampleW:0] wide;
      logic signed [SampleW:0] r;
      wide = {x[SampleW-1], x};
      if (wide > PiS) begin
         r = wide - TwoPiS;
      end else if (wide <= NegBound) begin
         r = wide + TwoPiS;
      end else begin
         r = wide;
      end
      return r[SampleW-1:0];
   endfunction

endpackage

FILE: hw/rtl/jmta_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered, read-first data.
// ----------------------------------------------------------------------------
module jmta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/jmta_update.sv
// ----------------------------------------------------------------------------
// Joint angle update
// Computes a joint's next tracker state and its result from one request.
// ----------------------------------------------------------------------------
module jmta_update
   import jmta_pkg::*;
(
   input  op_type          op,
   input  logic            in_range,
   input  sample_type      sample,
   input  thr_type         threshold,
   input  joint_state_type cur,
   output joint_state_type nxt,
   output ext_type         result,
   output logic            saturated
);

   logic signed [SampleW:0]   diff;
   logic [SampleW:0]          mag;
   logic                      jump;
   sample_type                ns;
   sample_type                np;
   logic signed [SampleW:0]   delta;
   logic signed [ExtW+1:0]    sum;
   logic signed [SampleW+1:0] rd;
   logic signed [SampleW+1:0] r;
   logic signed [SampleW+1:0] t22;
   logic                      neg;
   logic                      clip_hi;
   logic                      clip_lo;
   joint_state_type           upd;

   always_comb begin
      ns    = norm_angle(sample);
      np    = norm_angle(cur.previous);
      diff  = {sample[SampleW-1], sample} - {cur.previous[SampleW-1], cur.previous};
      mag   = diff[SampleW] ? (SampleW+1)'(-diff) : (SampleW+1)'(diff);
      jump  = mag >= {2'b00, threshold};
      delta = {ns[SampleW-1], ns} - {np[SampleW-1], np};
      neg   = cur.extended[ExtW-1];
      t22   = (SampleW+2)'(TwoPiS);

      // The remainder by one turn follows the stored one, so no division is needed.
      if (jump) begin
         sum = (ExtW+2)'(cur.extended) + (ExtW+2)'(delta);
         rd  = (SampleW+2)'(cur.remainder) + (SampleW+2)'(delta);
      end else begin
         sum = (ExtW+2)'(cur.extended) - (ExtW+2)'(cur.remainder) + (ExtW+2)'(sample)
               - (neg ? (ExtW+2)'(TwoPiS) : (ExtW+2)'(0));
         rd  = (SampleW+2)'(sample);
      end

      if (!sum[ExtW+1]) begin
         if (rd < -t22) begin
            r = rd + t22 + t22;
         end else if (rd < 0) begin
            r = rd + t22;
         end else if (rd < t22) begin
            r = rd;
         end else begin
            r = rd - t22;
         end
      end else begin
         if (rd > t22) begin
            r = rd - t22 - t22;
         end else if (rd > 0) begin
            r = rd - t22;
         end else if (rd > -t22) begin
            r = rd;
         end else begin
            r = rd + t22;
         end
      end

      clip_hi = sum > (ExtW+2)'(ExtMaxQ);
      clip_lo = sum < (ExtW+2)'(ExtMinQ);

      upd.initialized = cur.initialized;
      upd.previous    = sample;
      if (clip_hi) begin
         upd.extended  = ExtMaxQ;
         upd.remainder = RemMax;
      end else if (clip_lo) begin
         upd.extended  = ExtMinQ;
         upd.remainder = RemMin;
      end else begin
         upd.extended  = sum[ExtW-1:0];
         upd.remainder = r[SampleW-1:0];
      end

      nxt       = cur;
      result    = '0;
      saturated = 1'b0;
      if (in_range) begin
         case (op)
            OP_INIT: begin
               if (!cur.initialized) begin
                  nxt.initialized = 1'b1;
                  nxt.previous    = ns;
                  nxt.remainder   = ns;
                  nxt.extended    = ExtW'(ns);
               end
               result = nxt.extended;
            end
            OP_UPDATE: begin
               nxt       = upd;
               result    = upd.extended;
               saturated = clip_hi | clip_lo;
            end
            default: begin
               nxt = cur;
            end
         endcase
      end
   end

endmodule

FILE: hw/rtl/multi_turn_joint_angle_tracker.sv
// ----------------------------------------------------------------------------
// Multi-turn joint angle tracker
// Unwraps single-turn joint angles into saturated multi-turn angles per joint.
// ----------------------------------------------------------------------------
// Requests pass the input stage and response register, one per cycle unless
// the response stalls. The rate is set by the per-joint state RAM
// read-modify-write, with the last write forwarded to the next request.
// Reset clears the per-joint valid bits, so every joint reads as zero and
// uninitialized, and sets the jump threshold to 205887. No clearing pass runs.
module multi_turn_joint_angle_tracker
   import jmta_pkg::*;
#(
   parameter int NUM_JOINTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // joint_index[2:0], sensor_angle[22:3]
   input  logic [0:0]  req_tuser,   // op[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // joint_out[2:0], extended_angle[50:3]
   output logic [0:0]  rsp_tuser,   // saturated[0]
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [23:0] csr_tdata    // jump_threshold[18:0]
);

   localparam int AW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
   localparam int IW = (AW > 3) ? AW : 3;
   localparam int SW = $bits(joint_state_type);

   logic                  req_accept;
   logic                  s1_adv;
   logic [2:0]            req_joint;
   logic [IW-1:0]         req_jx;
   logic [AW-1:0]         req_addr;
   logic                  req_in_range;

   logic                  s1_valid_ff;
   op_type                s1_op_ff;
   logic [2:0]            s1_joint_ff;
   sample_type            s1_sample_ff;
   logic                  s1_in_range_ff;
   logic                  s1_entry_ok_ff;
   logic [IW-1:0]         s1_jx;
   logic [AW-1:0]         s1_addr;

   logic [NUM_JOINTS-1:0] valid_ff;
   logic [NUM_JOINTS-1:0] valid_in;
   logic                  fwd_valid_ff;
   logic [AW-1:0]         fwd_addr_ff;
   joint_state_type       fwd_state_ff;

   logic [SW-1:0]         ram_rd_data;
   logic                  wr_en;
   joint_state_type       cur_state;
   joint_state_type       nxt_state;
   ext_type               result;
   logic                  saturated;

   logic                  rsp_valid_ff;
   logic [2:0]            rsp_joint_ff;
   ext_type               rsp_ext_ff;
   logic                  rsp_sat_ff;
   thr_type               thr_ff;

   assign req_joint    = req_tdata[2:0];
   assign req_jx       = IW'(req_joint);
   assign req_addr     = req_jx[AW-1:0];
   assign req_in_range = {4'b0000, req_joint} < 7'(NUM_JOINTS);
   assign s1_jx        = IW'(s1_joint_ff);
   assign s1_addr      = s1_jx[AW-1:0];

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_accept = req_tvalid && req_tready;
   assign wr_en      = s1_adv && s1_in_range_ff;
   assign csr_tready = 1'b1;

   jmta_ram #(
      .WIDTH(SW),
      .DEPTH(NUM_JOINTS)
   ) u_state_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(s1_addr),
      .wr_data(nxt_state),
      .rd_en  (req_accept),
      .rd_addr(req_addr),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == s1_addr)) begin
         cur_state = fwd_state_ff;
      end else if (s1_entry_ok_ff) begin
         cur_state = joint_state_type'(ram_rd_data);
      end else begin
         cur_state = '0;
      end
   end

   jmta_update u_update (
      .op       (s1_op_ff),
      .in_range (s1_in_range_ff),
      .sample   (s1_sample_ff),
      .threshold(thr_ff),
      .cur      (cur_state),
      .nxt      (nxt_state),
      .result   (result),
      .saturated(saturated)
   );

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[s1_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_valid_ff <= 1'b0;
         valid_ff     <= '0;
         thr_ff       <= ThrReset;
      end else begin
         valid_ff <= valid_in;
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (wr_en) begin
            fwd_valid_ff <= 1'b1;
         end
         if (csr_tvalid) begin
            thr_ff <= csr_tdata[ThrW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff       <= op_type'(req_tuser[0]);
         s1_joint_ff    <= req_joint;
         s1_sample_ff   <= req_tdata[22:3];
         s1_in_range_ff <= req_in_range;
         s1_entry_ok_ff <= req_in_range && valid_ff[req_addr];
      end
      if (wr_en) begin
         fwd_addr_ff  <= s1_addr;
         fwd_state_ff <= nxt_state;
      end
      if (s1_adv) begin
         rsp_joint_ff <= s1_joint_ff;
         rsp_ext_ff   <= result;
         rsp_sat_ff   <= saturated;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_ext_ff, rsp_joint_ff};
   assign rsp_tuser  = rsp_sat_ff;

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sat_ff) |-> (rsp_ext_ff == ExtMaxQ || rsp_ext_ff == ExtMinQ))
      else $error("Saturated response is not at a range limit.");

   a_rem_sign: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ((nxt_state.extended[ExtW-1] ? (nxt_state.remainder <= 0)
                                              : (nxt_state.remainder >= 0))
                 && (nxt_state.remainder < TwoPiS)
                 && (nxt_state.remainder > -TwoPiS)))
      else $error("Stored turn remainder disagrees with the extended angle.");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("Accepted request did not reach the input stage.");

   a_adv_responds: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> (rsp_valid_ff && (rsp_joint_ff == $past(s1_joint_ff))))
      else $error("Advancing request did not produce its response.");

endmodule
